// File: design/cdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsc_pkg
// Shared types and constants for the clock display / time-set controller.
// ----------------------------------------------------------------------------
package cdsc_pkg;

  // event kinds carried in s_axis_tuser
  localparam logic [1:0] EV_SECOND = 2'd0;
  localparam logic [1:0] EV_TICK   = 2'd1;
  localparam logic [1:0] EV_MODE   = 2'd2;
  localparam logic [1:0] EV_ADJUST = 2'd3;

  // clock chip register indexes
  localparam logic [1:0] RTC_SEC  = 2'd0;
  localparam logic [1:0] RTC_MIN  = 2'd1;
  localparam logic [1:0] RTC_HOUR = 2'd2;

  // stage codes as reported on the output
  localparam logic [1:0] STG_RUN  = 2'd0;
  localparam logic [1:0] STG_HOUR = 2'd1;
  localparam logic [1:0] STG_MIN  = 2'd2;
  localparam logic [1:0] STG_SEC  = 2'd3;

  localparam int TICK_W = 3;

  localparam logic [7:0] HIDDEN_PAIR = 8'hAA;  // both digits out of 0-9, so blank
  localparam logic [5:0] NIGHT_FROM  = 6'h21;
  localparam logic [5:0] NIGHT_UNTIL = 6'h07;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hFC, 8'h84, 8'hBA, 8'hAE, 8'hC6, 8'h6E, 8'h7E, 8'hA4, 8'hFE, 8'hEE
  };

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_HOUR = 4'b0010,
    ST_MIN  = 4'b0100,
    ST_SEC  = 4'b1000
  } stage_t;

  typedef struct packed {
    logic [7:0] right_ones;
    logic [7:0] right_tens;
    logic [7:0] left_ones;
    logic [7:0] left_tens;
  } seg_t;

  // digit above 9 shows blank
  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    s = 8'h00;
    if (d < 4'd10) begin
      s = SEG_TABLE[d];
    end
    return s;
  endfunction

endpackage

// File: design/cdsc_disp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsc_disp
// Turns the left and right BCD pairs and the colon into four segment bytes.
// ----------------------------------------------------------------------------
module cdsc_disp (
  input  logic [7:0]    left_pair,
  input  logic [7:0]    right_pair,
  input  logic          colon,
  output cdsc_pkg::seg_t seg
);

  always_comb begin
    // leading zero on the left is blanked
    seg.left_tens  = (left_pair[7:4] != 4'd0) ? cdsc_pkg::digit_seg(left_pair[7:4]) : 8'h00;
    seg.left_ones  = cdsc_pkg::digit_seg(left_pair[3:0]);
    seg.right_tens = cdsc_pkg::digit_seg(right_pair[7:4]);
    seg.right_ones = cdsc_pkg::digit_seg(right_pair[3:0]) | {7'd0, colon};
  end

endmodule

// File: design/clock_display_set_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_display_set_controller_top
// Clock display and time-set controller: one event word in, one display word out.
// ----------------------------------------------------------------------------
// Takes one event word per clock (second pulse, 50 ms tick, mode key, adjust
// key, with the BCD time from the clock chip) and answers each with one word:
// four segment bytes, brightness, an optional clock-chip register write and
// the stage. An event passes through an input register and a result register.
// The result word is offered from the result register, and a new
// word can be taken every cycle while the output side keeps up. While a result
// waits downstream the input register holds one more event, and after that
// the input stalls until the result is taken.
module clock_display_set_controller_top #(
  parameter int TICKS_PER_BLINK = 5  // 1..7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] hour_bcd, [12:6] minute_bcd, [19:13] second_bcd, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] seg_left_tens, [15:8] seg_left_ones, [23:16] seg_right_tens,
  // [31:24] seg_right_ones, [32] night_dim, [33] rtc_write, [35:34] rtc_reg,
  // [42:36] rtc_value, [44:43] stage, [47:45] zero
  output logic [47:0] m_axis_tdata
);

  localparam logic [cdsc_pkg::TICK_W-1:0] TPB = cdsc_pkg::TICK_W'(TICKS_PER_BLINK);

  // input register
  logic       in_valid;
  logic [1:0] in_mode;
  logic [5:0] in_hour;
  logic [6:0] in_minute;
  logic [6:0] in_second;

  // state
  cdsc_pkg::stage_t stage, stage_next;
  logic colon_on, colon_on_next;
  logic blink_show, blink_show_next;
  logic [cdsc_pkg::TICK_W-1:0] tick_count, tick_count_next, tick_inc;
  logic night_reg, night_reg_next;

  // result register
  logic       out_valid;
  cdsc_pkg::seg_t out_seg;
  logic       out_night;
  logic       out_write;
  logic [1:0] out_reg;
  logic [6:0] out_value;
  logic [1:0] out_stage;

  logic       fire;
  logic       wr;
  logic [1:0] wreg;
  logic [6:0] wval;
  logic       forced;
  logic [7:0] hour_pair, minute_pair, second_pair, left_pair, right_pair;
  logic       colon;
  logic [1:0] stage_code;
  cdsc_pkg::seg_t seg;

  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  function automatic logic [6:0] to_bcd(input logic [5:0] b);
    logic [2:0] t;
    logic [5:0] tx10;
    logic [5:0] o;
    if (b >= 6'd50) begin
      t = 3'd5;
    end else if (b >= 6'd40) begin
      t = 3'd4;
    end else if (b >= 6'd30) begin
      t = 3'd3;
    end else if (b >= 6'd20) begin
      t = 3'd2;
    end else if (b >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    tx10 = {3'd0, t} * 6'd10;
    o    = b - tx10;
    return {t, o[3:0]};
  endfunction

  // BCD increment with wrap at the modulus; non-BCD input still yields valid BCD
  function automatic logic [6:0] bcd_step(input logic [3:0] tens, input logic [3:0] ones,
                                          input logic [7:0] modulus);
    logic [7:0] v;
    v = {4'd0, tens} * 8'd10 + {4'd0, ones} + 8'd1;
    if (v >= modulus) begin
      v = 8'd0;
    end
    return to_bcd(v[5:0]);
  endfunction

  function automatic logic night_of(input logic [5:0] h);
    return (h >= cdsc_pkg::NIGHT_FROM) || (h < cdsc_pkg::NIGHT_UNTIL);
  endfunction

  always_comb begin
    stage_next      = stage;
    colon_on_next   = colon_on;
    blink_show_next = blink_show;
    tick_count_next = tick_count;
    night_reg_next  = night_reg;
    tick_inc        = tick_count + cdsc_pkg::TICK_W'(1);
    wr              = 1'b0;
    wreg            = cdsc_pkg::RTC_SEC;
    wval            = 7'd0;
    forced          = 1'b0;
    hour_pair       = {2'd0, in_hour};
    minute_pair     = {1'b0, in_minute};
    second_pair     = {1'b0, in_second};

    case (in_mode)
      cdsc_pkg::EV_SECOND: begin
        if (stage == cdsc_pkg::ST_RUN) begin
          colon_on_next  = !colon_on;
          night_reg_next = night_of(in_hour);
        end
      end
      cdsc_pkg::EV_TICK: begin
        if (stage == cdsc_pkg::ST_HOUR || stage == cdsc_pkg::ST_MIN) begin
          if (tick_inc >= TPB) begin
            tick_count_next = '0;
            blink_show_next = !blink_show;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      cdsc_pkg::EV_MODE: begin
        case (stage)
          cdsc_pkg::ST_RUN:  stage_next = cdsc_pkg::ST_HOUR;
          cdsc_pkg::ST_HOUR: stage_next = cdsc_pkg::ST_MIN;
          cdsc_pkg::ST_MIN:  stage_next = cdsc_pkg::ST_SEC;
          default:           stage_next = cdsc_pkg::ST_RUN;
        endcase
        if (stage_next == cdsc_pkg::ST_RUN) begin
          night_reg_next = night_of(in_hour);
        end else begin
          colon_on_next = 1'b1;
        end
      end
      default: begin
        case (stage)
          cdsc_pkg::ST_HOUR: begin
            wr        = 1'b1;
            wreg      = cdsc_pkg::RTC_HOUR;
            wval      = bcd_step({2'd0, in_hour[5:4]}, in_hour[3:0], 8'd24);
            hour_pair = {1'b0, wval};
            forced    = 1'b1;
          end
          cdsc_pkg::ST_MIN: begin
            wr          = 1'b1;
            wreg        = cdsc_pkg::RTC_MIN;
            wval        = bcd_step({1'b0, in_minute[6:4]}, in_minute[3:0], 8'd60);
            minute_pair = {1'b0, wval};
            forced      = 1'b1;
          end
          cdsc_pkg::ST_SEC: begin
            wr          = 1'b1;
            wreg        = cdsc_pkg::RTC_SEC;
            second_pair = 8'd0;
          end
          default: ;
        endcase
      end
    endcase

    // display follows the stage after the event
    case (stage_next)
      cdsc_pkg::ST_RUN: begin
        left_pair  = hour_pair;
        right_pair = minute_pair;
        colon      = colon_on_next;
        stage_code = cdsc_pkg::STG_RUN;
      end
      cdsc_pkg::ST_HOUR: begin
        left_pair  = (blink_show_next || forced) ? hour_pair : cdsc_pkg::HIDDEN_PAIR;
        right_pair = minute_pair;
        colon      = 1'b1;
        stage_code = cdsc_pkg::STG_HOUR;
      end
      cdsc_pkg::ST_MIN: begin
        left_pair  = hour_pair;
        right_pair = (blink_show_next || forced) ? minute_pair : cdsc_pkg::HIDDEN_PAIR;
        colon      = 1'b1;
        stage_code = cdsc_pkg::STG_MIN;
      end
      default: begin
        left_pair  = cdsc_pkg::HIDDEN_PAIR;
        right_pair = second_pair;
        colon      = 1'b1;
        stage_code = cdsc_pkg::STG_SEC;
      end
    endcase
  end

  cdsc_disp u_disp (
    .left_pair  (left_pair),
    .right_pair (right_pair),
    .colon      (colon),
    .seg        (seg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode   <= s_axis_tuser;
      in_hour   <= s_axis_tdata[5:0];
      in_minute <= s_axis_tdata[12:6];
      in_second <= s_axis_tdata[19:13];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= cdsc_pkg::ST_RUN;
      colon_on   <= 1'b0;
      blink_show <= 1'b0;
      tick_count <= '0;
      night_reg  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        stage      <= stage_next;
        colon_on   <= colon_on_next;
        blink_show <= blink_show_next;
        tick_count <= tick_count_next;
        night_reg  <= night_reg_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_seg   <= seg;
      out_night <= night_reg_next;
      out_write <= wr;
      out_reg   <= wreg;
      out_value <= wval;
      out_stage <= stage_code;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_stage, out_value, out_reg, out_write, out_night,
                          out_seg.right_ones, out_seg.right_tens,
                          out_seg.left_ones, out_seg.left_tens};

  // assertions
  a_fire_gives_word: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed event produced no output word");

  a_write_not_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_write |-> out_stage != cdsc_pkg::STG_RUN)
    else $error("clock register write reported in run stage");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_write |-> out_reg == cdsc_pkg::RTC_SEC && out_value == 7'd0)
    else $error("register fields not zero without a write");

  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    tick_count < TPB)
    else $error("tick counter passed blink period");

  a_mode_steps: assert property (@(posedge clk) disable iff (rst)
    fire && in_mode == cdsc_pkg::EV_MODE |=> stage != $past(stage))
    else $error("mode key did not change stage");

endmodule

// File: tb/clock_display_set_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_display_set_controller_top_tb
// Self-checking bench for the clock display / time-set controller.
// ----------------------------------------------------------------------------
// A short table of directed events covers the run-stage colon and night
// window, each set stage's adjust wrap or clear, the blink ticks and non-BCD
// time. A long random event stream follows. Every accepted event word is run
// through a behavioral model of the stage machine, and the expected display
// word is queued. Each output word is compared field by field with the oldest
// queued word. Both stream sides idle at random. The output side also holds
// off once for a long stretch, and the input side once drains the pipe.
// ----------------------------------------------------------------------------
module clock_display_set_controller_top_tb;

  localparam int TPB            = 5;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIR          = 28;
  localparam int N_RAND         = 2000;

  typedef struct packed {
    logic [2:0] pad;
    logic [1:0] stage;
    logic [6:0] rtc_value;
    logic [1:0] rtc_reg;
    logic       rtc_write;
    logic       night_dim;
    logic [7:0] seg_right_ones;
    logic [7:0] seg_right_tens;
    logic [7:0] seg_left_ones;
    logic [7:0] seg_left_tens;
  } disp_word_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [5:0] hr;
    logic [6:0] mn;
    logic [6:0] sc;
    logic       typed;
    disp_word_t word;
  } event_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [5:0] hour, [12:6] minute, [19:13] second
  logic [1:0]  s_axis_tuser = '0;  // [1:0] event kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] lt, [15:8] lo, [23:16] rt, [31:24] ro, [32] night, [33] write,
  // [35:34] reg, [42:36] value, [44:43] stage
  logic [47:0] m_axis_tdata;

  disp_word_t expected_words[$];
  int         fail_count = 0;
  bit         calm = 1'b0;      // no idling on either side
  bit         hold_go = 1'b0;   // ask the output side for its long hold-off

  // model state
  logic [1:0] stage_q = cdsc_pkg::STG_RUN;
  logic       colon_q = 1'b0;
  logic       blink_q = 1'b0;
  logic [2:0] tick_q  = '0;
  logic       night_q = 1'b0;

  event_row_t dir_rows [N_DIR] = '{
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h34, 7'h56, 1'b1, 48'h0000_C6AE_BA84},
    '{cdsc_pkg::EV_SECOND, 6'h00, 7'h00, 7'h00, 1'b1, 48'h0001_FDFC_FC00},
    '{cdsc_pkg::EV_SECOND, 6'h23, 7'h59, 7'h59, 1'b0, 48'h0},
    '{cdsc_pkg::EV_SECOND, 6'h20, 7'h59, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_SECOND, 6'h3F, 7'h7F, 7'h7F, 1'b0, 48'h0},
    '{cdsc_pkg::EV_SECOND, 6'h07, 7'h00, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_SECOND, 6'h06, 7'h00, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_SECOND, 6'h21, 7'h00, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_MODE,   6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h23, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h3F, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h09, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_SECOND, 6'h12, 7'h45, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_MODE,   6'h12, 7'h59, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h12, 7'h59, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h12, 7'h7F, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h12, 7'h09, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h09, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_MODE,   6'h12, 7'h09, 7'h30, 1'b0, 48'h0},
    // seconds clear: left pair blank, 00 on the right, colon lit
    '{cdsc_pkg::EV_ADJUST, 6'h12, 7'h09, 7'h30, 1'b1, 48'h1803_FDFC_0000},
    '{cdsc_pkg::EV_TICK,   6'h12, 7'h09, 7'h30, 1'b0, 48'h0},
    '{cdsc_pkg::EV_MODE,   6'h08, 7'h00, 7'h00, 1'b0, 48'h0},
    '{cdsc_pkg::EV_ADJUST, 6'h08, 7'h00, 7'h00, 1'b0, 48'h0}
  };

  clock_display_set_controller_top #(
    .TICKS_PER_BLINK(TPB)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    case (d)
      4'd0: return 8'hFC;
      4'd1: return 8'h84;
      4'd2: return 8'hBA;
      4'd3: return 8'hAE;
      4'd4: return 8'hC6;
      4'd5: return 8'h6E;
      4'd6: return 8'h7E;
      4'd7: return 8'hA4;
      4'd8: return 8'hFE;
      4'd9: return 8'hEE;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic night_hour(input logic [7:0] hr);
    return (hr >= {2'b0, cdsc_pkg::NIGHT_FROM}) || (hr < {2'b0, cdsc_pkg::NIGHT_UNTIL});
  endfunction

  // non-BCD digits fold into tens*10+ones; reaching the modulus wraps to zero
  function automatic logic [6:0] bcd_advance(input logic [7:0] bcd, input int modulus);
    int v;
    v = int'(bcd[7:4]) * 10 + int'(bcd[3:0]) + 1;
    if (v >= modulus) v = 0;
    return 7'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic disp_word_t predict_display(input logic [1:0] ev, input logic [5:0] hr,
      input logic [6:0] mn, input logic [6:0] sc);
    disp_word_t w;
    logic [7:0] hour_v, min_v, sec_v, left, right;
    logic       forced, colon;
    w      = '0;
    hour_v = {2'b0, hr};
    min_v  = {1'b0, mn};
    sec_v  = {1'b0, sc};
    forced = 1'b0;
    case (ev)
      cdsc_pkg::EV_SECOND: begin
        if (stage_q == cdsc_pkg::STG_RUN) begin
          colon_q = ~colon_q;
          night_q = night_hour(hour_v);
        end
      end
      cdsc_pkg::EV_TICK: begin
        if (stage_q == cdsc_pkg::STG_HOUR || stage_q == cdsc_pkg::STG_MIN) begin
          tick_q = tick_q + 3'd1;
          if (tick_q >= TPB) begin
            tick_q  = '0;
            blink_q = ~blink_q;
          end
        end
      end
      cdsc_pkg::EV_MODE: begin
        stage_q = stage_q + 2'd1;
        if (stage_q == cdsc_pkg::STG_RUN) night_q = night_hour(hour_v);
        else colon_q = 1'b1;
      end
      default: begin
        case (stage_q)
          cdsc_pkg::STG_HOUR: begin
            w.rtc_write = 1'b1;
            w.rtc_reg   = cdsc_pkg::RTC_HOUR;
            w.rtc_value = bcd_advance(hour_v, 24);
            hour_v      = {1'b0, w.rtc_value};
            forced      = 1'b1;
          end
          cdsc_pkg::STG_MIN: begin
            w.rtc_write = 1'b1;
            w.rtc_reg   = cdsc_pkg::RTC_MIN;
            w.rtc_value = bcd_advance(min_v, 60);
            min_v       = {1'b0, w.rtc_value};
            forced      = 1'b1;
          end
          cdsc_pkg::STG_SEC: begin
            w.rtc_write = 1'b1;
            w.rtc_reg   = cdsc_pkg::RTC_SEC;
            w.rtc_value = '0;
            sec_v       = '0;
          end
          default: ;
        endcase
      end
    endcase

    case (stage_q)
      cdsc_pkg::STG_RUN: begin
        left = hour_v; right = min_v; colon = colon_q;
      end
      cdsc_pkg::STG_HOUR: begin
        left  = (blink_q || forced) ? hour_v : cdsc_pkg::HIDDEN_PAIR;
        right = min_v; colon = 1'b1;
      end
      cdsc_pkg::STG_MIN: begin
        left  = hour_v;
        right = (blink_q || forced) ? min_v : cdsc_pkg::HIDDEN_PAIR;
        colon = 1'b1;
      end
      default: begin
        left = cdsc_pkg::HIDDEN_PAIR; right = sec_v; colon = 1'b1;
      end
    endcase

    // leading zero of the left pair stays dark
    w.seg_left_tens  = (left[7:4] != 4'd0) ? seg_pattern(left[7:4]) : 8'h00;
    w.seg_left_ones  = seg_pattern(left[3:0]);
    w.seg_right_tens = seg_pattern(right[7:4]);
    w.seg_right_ones = seg_pattern(right[3:0]) | {7'b0, colon};
    w.night_dim      = night_q;
    w.stage          = stage_q;
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic send_event(input logic [1:0] ev, input logic [5:0] hr, input logic [6:0] mn,
      input logic [6:0] sc, input logic typed, input disp_word_t typed_word);
    disp_word_t predicted;
    if (!calm && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, sc, mn, hr};
    s_axis_tuser  <= ev;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = predict_display(ev, hr, mn, sc);
    expected_words.push_back(typed ? typed_word : predicted);
  endtask

  // output side: check each word, random stalls, one long hold-off
  initial begin
    disp_word_t got, want;
    int         hold_cycles;
    bit         hold_done;
    hold_cycles = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_words.size() == 0) begin
          $error("unexpected output word 0x%012h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("seg_left_tens", 32'(want.seg_left_tens), 32'(got.seg_left_tens));
          check_field("seg_left_ones", 32'(want.seg_left_ones), 32'(got.seg_left_ones));
          check_field("seg_right_tens", 32'(want.seg_right_tens),
                      32'(got.seg_right_tens));
          check_field("seg_right_ones", 32'(want.seg_right_ones),
                      32'(got.seg_right_ones));
          check_field("night_dim", 32'(want.night_dim), 32'(got.night_dim));
          check_field("rtc_write", 32'(want.rtc_write), 32'(got.rtc_write));
          check_field("rtc_reg", 32'(want.rtc_reg), 32'(got.rtc_reg));
          check_field("rtc_value", 32'(want.rtc_value), 32'(got.rtc_value));
          check_field("stage", 32'(want.stage), 32'(got.stage));
        end
      end
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_cycles++;
        if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int          r, v;
    logic [1:0]  ev;
    logic [5:0]  hr;
    logic [6:0]  mn, sc;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_event(dir_rows[i].ev, dir_rows[i].hr, dir_rows[i].mn, dir_rows[i].sc,
                 dir_rows[i].typed, dir_rows[i].word);
    end

    for (int i = 0; i < N_RAND; i++) begin
      calm = (i >= 1200 && i < 1600);
      if (i == 400) hold_go = 1'b1;
      if (i == 1000) begin
        // drain the pipe before going on
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 20) ev = cdsc_pkg::EV_SECOND;
      else if (r < 50) ev = cdsc_pkg::EV_TICK;
      else if (r < 68) ev = cdsc_pkg::EV_MODE;
      else ev = cdsc_pkg::EV_ADJUST;
      // mostly legal BCD time, some raw bit patterns
      if ($urandom_range(0, 99) < 85) begin
        v  = $urandom_range(0, 23);
        hr = 6'(((v / 10) << 4) | (v % 10));
      end else begin
        hr = 6'($urandom);
      end
      if ($urandom_range(0, 99) < 85) begin
        v  = $urandom_range(0, 59);
        mn = 7'(((v / 10) << 4) | (v % 10));
      end else begin
        mn = 7'($urandom);
      end
      if ($urandom_range(0, 99) < 85) begin
        v  = $urandom_range(0, 59);
        sc = 7'(((v / 10) << 4) | (v % 10));
      end else begin
        sc = 7'($urandom);
      end
      send_event(ev, hr, mn, sc, 1'b0, '0);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: clock_display_set_controller_top.f
design/cdsc_pkg.sv
design/cdsc_disp.sv
design/clock_display_set_controller_top.sv
tb/clock_display_set_controller_top_tb.sv
